/* design/gbcc_pkg.sv */
// Shared types, coin table and defaults for the bounded-supply greedy coin splitter.
package gbcc_pkg;

  localparam int COIN_KINDS = 6;
  localparam int CNT_W      = 20;
  localparam int AMT_W      = 20;

  localparam int DEF_NUM_COINS   = 6;
  localparam int DEF_AMOUNT_BITS = 20;

  // Denominations, smallest first
  localparam int COIN_DENOM [COIN_KINDS] = '{1, 2, 5, 10, 25, 50};

  typedef logic [COIN_KINDS-1:0][CNT_W-1:0] cnt_arr_t;

  // Per-request side data that rides along the coin stages
  typedef struct packed {
    cnt_arr_t avail;
    cnt_arr_t used;
  } carry_t;

  typedef struct packed {
    logic [AMT_W-1:0] amount;
    logic [CNT_W-1:0] avail_1c;
    logic [CNT_W-1:0] avail_2c;
    logic [CNT_W-1:0] avail_5c;
    logic [CNT_W-1:0] avail_10c;
    logic [CNT_W-1:0] avail_25c;
    logic [CNT_W-1:0] avail_50c;
  } in_t;

  typedef struct packed {
    logic [19:0] use_1c;
    logic [18:0] use_2c;
    logic [17:0] use_5c;
    logic [16:0] use_10c;
    logic [15:0] use_25c;
    logic [14:0] use_50c;
    logic        split_ok;
  } out_t;

endpackage

/* design/gbcc_coin.sv */
// Two-stage pipeline slice for one denomination: quotient, then bounded take and subtract.
module gbcc_coin #(
  parameter int REST_W   = 20,
  parameter int COIN_IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [REST_W-1:0]   in_rest,
  input  gbcc_pkg::carry_t    in_carry,
  output logic                out_valid,
  output logic [REST_W-1:0]   out_rest,
  output gbcc_pkg::carry_t    out_carry
);

  localparam int D  = gbcc_pkg::COIN_DENOM[COIN_IDX];
  localparam int L  = $clog2(D);
  localparam int S  = REST_W + L;
  localparam int PW = 2*REST_W + 8;
  // ceil(2^S / D) gives an exact quotient for every REST_W-bit value
  localparam logic [63:0] RECIP64 = ((64'd1 << S) + 64'(D) - 64'd1) / 64'(D);
  localparam logic [PW-1:0] RECIP = RECIP64[PW-1:0];
  localparam logic [PW-1:0] DVAL  = PW'(D);

  // Stage A: quotient by reciprocal multiply
  logic                 va_r;
  logic [REST_W-1:0]    rest_a_r;
  gbcc_pkg::carry_t     car_a_r;
  logic [REST_W-1:0]    quo_r;
  logic [PW-1:0]        prod_a;
  logic [REST_W-1:0]    quo_nxt;

  assign prod_a  = PW'(in_rest) * RECIP;
  assign quo_nxt = prod_a[S +: REST_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rest_a_r <= in_rest;
      car_a_r  <= in_carry;
      quo_r    <= quo_nxt;
    end
  end

  // Stage B: clamp to the supply and subtract the coins taken
  logic                        vb_r;
  logic [REST_W-1:0]           rest_b_r;
  gbcc_pkg::carry_t            car_b_r;
  logic [gbcc_pkg::CNT_W-1:0]  have;
  logic [gbcc_pkg::CNT_W-1:0]  quo_ext;
  logic [gbcc_pkg::CNT_W-1:0]  take;
  logic [PW-1:0]               spent;
  logic [REST_W-1:0]           rest_b_nxt;
  gbcc_pkg::carry_t            car_b_nxt;

  always_comb begin
    have    = car_a_r.avail[COIN_IDX];
    quo_ext = gbcc_pkg::CNT_W'(quo_r);
    take    = (quo_ext > have) ? have : quo_ext;
    // take never exceeds the quotient, so it fits REST_W bits
    spent      = PW'(take[REST_W-1:0]) * DVAL;
    rest_b_nxt = rest_a_r - spent[REST_W-1:0];
    car_b_nxt  = car_a_r;
    car_b_nxt.used[COIN_IDX] = take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rest_b_r <= rest_b_nxt;
      car_b_r  <= car_b_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_rest  = rest_b_r;
  assign out_carry = car_b_r;

endmodule

/* design/greedy_bounded_coin_change.sv */
// Top level of the bounded-supply greedy coin splitter.
// Splits an amount over coins of 50, 25, 10, 5, 2 and 1, largest first, taking
// floor(rest / value) coins of each but never more than the supplied count.
// Only the NUM_COINS smallest coins take part (at most six); the rest report
// zero. The amount is cut to min(AMOUNT_BITS, 20) bits. Each coin is a two-stage
// slice (reciprocal-multiply quotient, then clamp and subtract), and a new request
// is taken every cycle unless the output stalls. The whole pipeline holds while a
// result is stalled at the output.
module greedy_bounded_coin_change #(
  parameter int NUM_COINS   = gbcc_pkg::DEF_NUM_COINS,
  parameter int AMOUNT_BITS = gbcc_pkg::DEF_AMOUNT_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  gbcc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output gbcc_pkg::out_t out_data
);

  localparam int NC     = (NUM_COINS > gbcc_pkg::COIN_KINDS) ? gbcc_pkg::COIN_KINDS
                                                             : NUM_COINS;
  localparam int REST_W = (AMOUNT_BITS < gbcc_pkg::AMT_W) ? AMOUNT_BITS : gbcc_pkg::AMT_W;

  logic                           adv;
  logic [NC:0]                    vld_s;
  logic [NC:0][REST_W-1:0]        rest_s;
  gbcc_pkg::carry_t [NC:0]        car_s;

  // Hold every stage while the finished result waits; refuse requests in reset
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv || !rst_n;

  assign vld_s[0]       = in_valid;
  assign rest_s[0]      = in_data.amount[REST_W-1:0];
  assign car_s[0].used  = '0;
  assign car_s[0].avail = {in_data.avail_50c, in_data.avail_25c, in_data.avail_10c,
                           in_data.avail_5c, in_data.avail_2c, in_data.avail_1c};

  // Largest active coin first
  for (genvar j = 0; j < NC; j++) begin : g_coin
    gbcc_coin #(
      .REST_W   (REST_W),
      .COIN_IDX (NC - 1 - j)
    ) u_coin (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (vld_s[j]),
      .in_rest   (rest_s[j]),
      .in_carry  (car_s[j]),
      .out_valid (vld_s[j+1]),
      .out_rest  (rest_s[j+1]),
      .out_carry (car_s[j+1])
    );
  end

  assign out_valid = vld_s[NC];

  always_comb begin
    out_data.use_1c   = car_s[NC].used[0][19:0];
    out_data.use_2c   = car_s[NC].used[1][18:0];
    out_data.use_5c   = car_s[NC].used[2][17:0];
    out_data.use_10c  = car_s[NC].used[3][16:0];
    out_data.use_25c  = car_s[NC].used[4][15:0];
    out_data.use_50c  = car_s[NC].used[5][14:0];
    out_data.split_ok = (rest_s[NC] == '0);
  end

endmodule
